// File: design/gha_pkg.sv
`timescale 1ns / 1ps
// shared constants for the generational handle allocator
// operation and status codes, threshold register format, free queue control word
package gha_pkg;

    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_DEAD = 2'd2;

    localparam int              THR_WIDTH = 11;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 11'd64;

    typedef struct packed {
        logic push;
        logic pop;
    } gha_fifo_op_t;

endpackage

// File: design/gha_slot_table.sv
`timescale 1ns / 1ps
// per-slot generation memory, one write port and two registered read ports
// port a forwards a write to the same address in the same cycle; uses gha_pkg
module gha_slot_table import gha_pkg::*; #(
    parameter int INDEX_WIDTH = 10,
    parameter int GEN_WIDTH   = 8
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [INDEX_WIDTH-1:0] wr_addr,
    input  logic [GEN_WIDTH-1:0]   wr_data,
    input  logic                   rda_en,
    input  logic [INDEX_WIDTH-1:0] rda_addr,
    output logic [GEN_WIDTH-1:0]   rda_data,
    input  logic                   rdb_en,
    input  logic [INDEX_WIDTH-1:0] rdb_addr,
    output logic [GEN_WIDTH-1:0]   rdb_data
);

    localparam int DEPTH = 1 << INDEX_WIDTH;

    logic [GEN_WIDTH-1:0] mem [DEPTH];
    logic [GEN_WIDTH-1:0] rda_data_reg;
    logic [GEN_WIDTH-1:0] rdb_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rda_en) begin
            if (wr_en && (wr_addr == rda_addr)) begin
                rda_data_reg <= wr_data;
            end else begin
                rda_data_reg <= mem[rda_addr];
            end
        end
        if (rdb_en) begin
            rdb_data_reg <= mem[rdb_addr];
        end
    end

    assign rda_data = rda_data_reg;
    assign rdb_data = rdb_data_reg;

endmodule

// File: design/gha_free_fifo.sv
`timescale 1ns / 1ps
// free index queue with a registered copy of the head entry
// head word is refetched every cycle, with write-through on a push; uses gha_pkg
module gha_free_fifo import gha_pkg::*; #(
    parameter int INDEX_WIDTH = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gha_fifo_op_t           op,
    input  logic [INDEX_WIDTH-1:0] push_data,
    output logic [INDEX_WIDTH-1:0] head_data,
    output logic [INDEX_WIDTH:0]   count
);

    localparam int DEPTH = 1 << INDEX_WIDTH;

    logic [INDEX_WIDTH-1:0] mem [DEPTH];
    logic [INDEX_WIDTH-1:0] head_reg;
    logic [INDEX_WIDTH-1:0] head_next;
    logic [INDEX_WIDTH-1:0] tail_reg;
    logic [INDEX_WIDTH:0]   count_reg;
    logic [INDEX_WIDTH:0]   count_next;
    logic [INDEX_WIDTH-1:0] head_data_reg;

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (op.pop) begin
            head_next  = head_reg + INDEX_WIDTH'(1);
            count_next = count_reg - (INDEX_WIDTH+1)'(1);
        end else if (op.push) begin
            count_next = count_reg + (INDEX_WIDTH+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (op.push) begin
                tail_reg <= tail_reg + INDEX_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (op.push) begin
            mem[tail_reg] <= push_data;
        end
        if (op.push && (tail_reg == head_next)) begin
            head_data_reg <= push_data;
        end else begin
            head_data_reg <= mem[head_next];
        end
    end

    assign head_data = head_data_reg;
    assign count     = count_reg;

endmodule

// File: design/generational_handle_allocator.sv
`timescale 1ns / 1ps
// generational handle allocator: create, destroy and alive query on slot handles
// top level; uses gha_pkg, gha_slot_table and gha_free_fifo
//
// input channel s_*: one operation word (func, handle index, handle generation)
// result channel m_*: one result word per operation (index, generation, alive, status)
// cfg_wr_en / cfg_wr_data write the reuse threshold, while idle
// an accepted word sits in an operation register while its generation is read
// from the slot table; it executes when the result register is free and its
// result is visible the cycle after
// throughput is one word per cycle while the receiver takes each result word, set by
// the update of the slot table and the free queue in the operation register stage
// a reuse reads the popped slot's generation on the table's second read port
// reset empties the free queue and the slot count; no clearing pass is needed,
// a slot's generation is written to zero when the slot is first handed out
// when the receiver stalls the result register holds, the operation register
// fills, and s_ready drops until the result word is taken
module generational_handle_allocator import gha_pkg::*; #(
    parameter int INDEX_WIDTH = 10,
    parameter int GEN_WIDTH   = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [THR_WIDTH-1:0]   cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_func,
    input  logic [INDEX_WIDTH-1:0] s_handle_index,
    input  logic [GEN_WIDTH-1:0]   s_handle_generation,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [INDEX_WIDTH-1:0] m_out_index,
    output logic [GEN_WIDTH-1:0]   m_out_generation,
    output logic                   m_is_alive,
    output logic [1:0]             m_status
);

    localparam int CNT_WIDTH = INDEX_WIDTH + 1;
    localparam int CMP_WIDTH = (CNT_WIDTH > THR_WIDTH) ? CNT_WIDTH : THR_WIDTH;

    logic [THR_WIDTH-1:0]   thr_reg;
    logic [CNT_WIDTH-1:0]   slots_used_reg;
    logic [CNT_WIDTH-1:0]   slots_used_next;

    logic                   op_valid_reg;
    logic [1:0]             op_func_reg;
    logic [INDEX_WIDTH-1:0] op_index_reg;
    logic [GEN_WIDTH-1:0]   op_gen_reg;

    logic                   m_valid_reg;
    logic [INDEX_WIDTH-1:0] m_index_reg;
    logic                   m_gen_sel_reg;
    logic                   m_alive_reg;
    logic [1:0]             m_status_reg;

    logic                   accept;
    logic                   exec;
    logic                   alive;
    logic                   reuse;

    logic [GEN_WIDTH-1:0]   cur_gen;
    logic [GEN_WIDTH-1:0]   reuse_gen;
    logic                   tbl_wr_en;
    logic [INDEX_WIDTH-1:0] tbl_wr_addr;
    logic [GEN_WIDTH-1:0]   tbl_wr_data;

    gha_fifo_op_t           fifo_op;
    logic [INDEX_WIDTH-1:0] fifo_head;
    logic [CNT_WIDTH-1:0]   fifo_count;

    logic [INDEX_WIDTH-1:0] res_index;
    logic                   res_gen_sel;
    logic                   res_alive;
    logic [1:0]             res_status;

    assign exec    = op_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !op_valid_reg || exec;
    assign accept  = s_valid && s_ready;

    assign alive = ({1'b0, op_index_reg} < slots_used_reg) && (cur_gen == op_gen_reg);
    assign reuse = CMP_WIDTH'(fifo_count) > CMP_WIDTH'(thr_reg);

    always_comb begin
        slots_used_next = slots_used_reg;
        tbl_wr_en       = 1'b0;
        tbl_wr_addr     = op_index_reg;
        tbl_wr_data     = cur_gen + GEN_WIDTH'(1);
        fifo_op         = '0;
        res_index       = '0;
        res_gen_sel     = 1'b0;
        res_alive       = 1'b0;
        res_status      = STATUS_OK;
        case (op_func_reg)
            OP_CREATE: begin
                if (reuse) begin
                    fifo_op.pop = exec;
                    res_index   = fifo_head;
                    res_gen_sel = 1'b1;
                end else if (slots_used_reg[INDEX_WIDTH]) begin
                    res_status = STATUS_FULL;
                end else begin
                    tbl_wr_en       = exec;
                    tbl_wr_addr     = slots_used_reg[INDEX_WIDTH-1:0];
                    tbl_wr_data     = '0;
                    res_index       = slots_used_reg[INDEX_WIDTH-1:0];
                    if (exec) begin
                        slots_used_next = slots_used_reg + CNT_WIDTH'(1);
                    end
                end
            end
            OP_DESTROY: begin
                if (alive) begin
                    tbl_wr_en    = exec;
                    fifo_op.push = exec && !fifo_count[INDEX_WIDTH];
                    res_alive    = 1'b1;
                end else begin
                    res_status = STATUS_DEAD;
                end
            end
            OP_QUERY: begin
                res_alive = alive;
            end
            default: begin
            end
        endcase
    end

    gha_slot_table #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .GEN_WIDTH   (GEN_WIDTH)
    ) u_slot_table (
        .aclk     (aclk),
        .wr_en    (tbl_wr_en),
        .wr_addr  (tbl_wr_addr),
        .wr_data  (tbl_wr_data),
        .rda_en   (accept),
        .rda_addr (s_handle_index),
        .rda_data (cur_gen),
        .rdb_en   (fifo_op.pop),
        .rdb_addr (fifo_head),
        .rdb_data (reuse_gen)
    );

    gha_free_fifo #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_free_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (fifo_op),
        .push_data (op_index_reg),
        .head_data (fifo_head),
        .count     (fifo_count)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg        <= THR_RESET;
            slots_used_reg <= '0;
            op_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            slots_used_reg <= slots_used_next;
            if (s_ready) begin
                op_valid_reg <= s_valid;
            end
            if (exec) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_func_reg  <= s_func;
            op_index_reg <= s_handle_index;
            op_gen_reg   <= s_handle_generation;
        end
        if (exec) begin
            m_index_reg   <= res_index;
            m_gen_sel_reg <= res_gen_sel;
            m_alive_reg   <= res_alive;
            m_status_reg  <= res_status;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_index      = m_index_reg;
    assign m_out_generation = m_gen_sel_reg ? reuse_gen : '0;
    assign m_is_alive       = m_alive_reg;
    assign m_status         = m_status_reg;

endmodule
